### design/blb_pkg.sv
// shared constants and types for the bidirectional line blur
package blb_pkg;

  localparam int LINE_WIDTH = 64;
  localparam int COL_W      = 6;
  localparam int ADDR_W     = COL_W + 1;
  localparam int PIX_W      = 8;
  localparam int STR_W      = 17;
  localparam int LEVEL_W    = 24;
  localparam int FRAC_W     = 16;
  localparam int BLEVEL_W   = 9;
  localparam int WORD_W     = 2 * PIX_W;

  localparam logic [COL_W-1:0]    LastCol     = COL_W'(LINE_WIDTH - 1);
  localparam logic [STR_W-1:0]    StrengthOne = 17'h10000;
  localparam logic [STR_W-1:0]    StrengthRst = 17'h08000;
  localparam logic [PIX_W-1:0]    PixMax      = 8'd255;
  localparam logic [BLEVEL_W-1:0] BLevelMax   = 9'd511;

  // one write into the line store: source pixel in the upper byte
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } store_wr_t;

endpackage

### design/blb_line_store.sv
// two-bank line store holding source and forward pixels per column
module blb_line_store (
  input  logic                       clk_i,
  input  blb_pkg::store_wr_t         wr_i,
  input  logic [blb_pkg::ADDR_W-1:0] rd_addr_i,
  output logic [blb_pkg::WORD_W-1:0] rd_data_o
);

  logic [blb_pkg::WORD_W-1:0] mem_q [2**blb_pkg::ADDR_W];
  logic [blb_pkg::WORD_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

### design/blb_line_queue.sv
// two-entry queue of finished line banks between front and back
module blb_line_queue (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  logic bank_i,
  input  logic pop_i,
  output logic empty_o,
  output logic bank_o
);

  logic       bank_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wptr_d = push_i ? ~wptr_q : wptr_q;
    rptr_d = pop_i ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      bank_q[wptr_q] <= bank_i;
    end
  end

  assign empty_o = (cnt_q == 2'd0);
  assign bank_o  = bank_q[rptr_q];

endmodule

### design/blb_front.sv
// front end: takes pixels, runs the forward smoother, fills the line store
module blb_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [blb_pkg::PIX_W-1:0] pixel_i,
  input  logic [blb_pkg::STR_W-1:0] strength_i,
  input  logic                      release_i,
  output blb_pkg::store_wr_t        wr_o,
  output logic                      line_push_o,
  output logic                      line_bank_o
);

  logic [blb_pkg::COL_W-1:0]   col_q, col_d;
  logic                        bank_q, bank_d;
  logic [1:0]                  busy_q, busy_d;
  logic [blb_pkg::LEVEL_W-1:0] level_q, level_d;

  logic                        accept;
  logic                        line_done;
  logic [blb_pkg::LEVEL_W-1:0] level_cur;
  logic signed [24:0]          diff;
  logic signed [42:0]          prod;
  logic signed [26:0]          step;
  logic [blb_pkg::LEVEL_W-1:0] level_new;

  assign full      = (busy_q == 2'd2);
  assign accept    = push && !full;
  assign line_done = accept && (col_q == blb_pkg::LastCol);

  always_comb begin
    // a new line restarts the level at its first pixel
    level_cur = (col_q == '0) ? {pixel_i, 16'h0000} : level_q;
    diff      = $signed({1'b0, pixel_i, 16'h0000}) - $signed({1'b0, level_cur});
    prod      = diff * $signed({1'b0, strength_i});
    step      = 27'(prod >>> blb_pkg::FRAC_W);
    level_new = blb_pkg::LEVEL_W'($signed({3'b000, level_cur}) + step);

    level_d = accept ? level_new : level_q;
    col_d   = col_q;
    bank_d  = bank_q;
    if (accept) begin
      col_d = line_done ? '0 : col_q + 1'b1;
    end
    if (line_done) begin
      bank_d = ~bank_q;
    end
    busy_d = busy_q + 2'(line_done) - 2'(release_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      bank_q  <= 1'b0;
      busy_q  <= 2'd0;
      level_q <= '0;
    end else begin
      col_q   <= col_d;
      bank_q  <= bank_d;
      busy_q  <= busy_d;
      level_q <= level_d;
    end
  end

  always_comb begin
    wr_o.en   = accept;
    wr_o.addr = {bank_q, col_q};
    wr_o.data = {pixel_i, level_new[blb_pkg::LEVEL_W-1:blb_pkg::FRAC_W]};
  end

  assign line_push_o = line_done;
  assign line_bank_o = bank_q;

endmodule

### design/blb_back.sv
// back end: backward walk over a stored line, then in-order emission
module blb_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       line_empty_i,
  input  logic                       line_bank_i,
  output logic                       line_pop_o,
  output logic [blb_pkg::ADDR_W-1:0] rd_addr_o,
  input  logic [blb_pkg::WORD_W-1:0] rd_data_i,
  input  logic [blb_pkg::STR_W-1:0]  strength_i,
  output logic                       release_o,
  input  logic                       pop,
  output logic                       empty,
  output logic [blb_pkg::PIX_W-1:0]  pixel_out_o,
  output logic [blb_pkg::COL_W-1:0]  column_o,
  output logic                       last_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StWalk = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]                   state_q, state_d;
  logic                         bank_q, bank_d;
  logic                         iss_q, iss_d;
  logic [blb_pkg::COL_W-1:0]    rd_col_q, rd_col_d;
  logic                         vld_q, vld_d;
  logic [blb_pkg::COL_W-1:0]    proc_col_q, proc_col_d;
  logic                         first_q, first_d;
  logic [blb_pkg::BLEVEL_W-1:0] blevel_q, blevel_d;
  logic [blb_pkg::COL_W-1:0]    em_col_q, em_col_d;
  logic                         out_valid_q, out_valid_d;
  logic [blb_pkg::PIX_W-1:0]    out_pix_q;
  logic [blb_pkg::COL_W-1:0]    out_col_q;

  logic [blb_pkg::PIX_W-1:0]    res_mem_q [blb_pkg::LINE_WIDTH];

  logic [blb_pkg::PIX_W-1:0]    src;
  logic [blb_pkg::PIX_W-1:0]    fwd;
  logic [blb_pkg::BLEVEL_W-1:0] b_in;
  logic signed [9:0]            d;
  logic signed [27:0]           prod;
  logic signed [27:0]           prod_adj;
  logic signed [11:0]           q;
  logic signed [12:0]           b_wide;
  logic [blb_pkg::BLEVEL_W-1:0] b_new;
  logic [9:0]                   sum;
  logic [blb_pkg::PIX_W-1:0]    res;
  logic                         res_we;
  logic                         fetch;

  always_comb begin
    src  = rd_data_i[blb_pkg::WORD_W-1:blb_pkg::PIX_W];
    fwd  = rd_data_i[blb_pkg::PIX_W-1:0];
    // backward level starts at the forward value of the end column
    b_in = first_q ? {1'b0, fwd} : blevel_q;
    d    = $signed({2'b00, src}) - $signed({1'b0, b_in});
    prod = d * $signed({1'b0, strength_i});
    // truncate toward zero
    prod_adj = prod[27] ? prod + 28'sd65535 : prod;
    q        = 12'(prod_adj >>> blb_pkg::FRAC_W);
    b_wide   = $signed({4'b0000, b_in}) + 13'(q);
    if (b_wide < 0) begin
      b_new = '0;
    end else if (b_wide > $signed({4'b0000, blb_pkg::BLevelMax})) begin
      b_new = blb_pkg::BLevelMax;
    end else begin
      b_new = b_wide[blb_pkg::BLEVEL_W-1:0];
    end
    sum = {2'b00, fwd} + {1'b0, b_new};
    if (proc_col_q == '0) begin
      res = fwd;
    end else if (sum > {2'b00, blb_pkg::PixMax}) begin
      res = blb_pkg::PixMax;
    end else begin
      res = sum[blb_pkg::PIX_W-1:0];
    end
  end

  assign fetch  = (state_q == StEmit) && (!out_valid_q || pop);
  assign res_we = (state_q == StWalk) && vld_q;

  always_comb begin
    state_d     = state_q;
    bank_d      = bank_q;
    iss_d       = iss_q;
    rd_col_d    = rd_col_q;
    vld_d       = 1'b0;
    proc_col_d  = proc_col_q;
    first_d     = first_q;
    blevel_d    = blevel_q;
    em_col_d    = em_col_q;
    line_pop_o  = 1'b0;
    release_o   = 1'b0;
    out_valid_d = out_valid_q;
    if (pop) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (!line_empty_i) begin
          line_pop_o = 1'b1;
          bank_d     = line_bank_i;
          rd_col_d   = blb_pkg::LastCol;
          iss_d      = 1'b1;
          first_d    = 1'b1;
          state_d    = StWalk;
        end
      end
      StWalk: begin
        if (iss_q) begin
          vld_d      = 1'b1;
          proc_col_d = rd_col_q;
          if (rd_col_q == '0) begin
            iss_d = 1'b0;
          end else begin
            rd_col_d = rd_col_q - 1'b1;
          end
        end
        if (vld_q) begin
          first_d  = 1'b0;
          blevel_d = b_new;
          if (proc_col_q == '0) begin
            release_o = 1'b1;
            em_col_d  = '0;
            state_d   = StEmit;
          end
        end
      end
      StEmit: begin
        if (fetch) begin
          out_valid_d = 1'b1;
          if (em_col_q == blb_pkg::LastCol) begin
            state_d = StIdle;
          end else begin
            em_col_d = em_col_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      bank_q      <= 1'b0;
      iss_q       <= 1'b0;
      rd_col_q    <= '0;
      vld_q       <= 1'b0;
      proc_col_q  <= '0;
      first_q     <= 1'b0;
      blevel_q    <= '0;
      em_col_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bank_q      <= bank_d;
      iss_q       <= iss_d;
      rd_col_q    <= rd_col_d;
      vld_q       <= vld_d;
      proc_col_q  <= proc_col_d;
      first_q     <= first_d;
      blevel_q    <= blevel_d;
      em_col_q    <= em_col_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result buffer, read data doubles as the output register
  always_ff @(posedge clk_i) begin
    if (res_we) begin
      res_mem_q[proc_col_q] <= res;
    end
    if (fetch) begin
      out_pix_q <= res_mem_q[em_col_q];
      out_col_q <= em_col_q;
    end
  end

  assign rd_addr_o   = {bank_q, rd_col_q};
  assign empty       = !out_valid_q;
  assign pixel_out_o = out_pix_q;
  assign column_o    = out_col_q;
  assign last_o      = (out_col_q == blb_pkg::LastCol);

endmodule

### design/bidirectional_line_blur_unit.sv
// top level of the bidirectional line blur
// Usage: pixels of a 64-column line enter left to right through push/full; a
// request is taken at a clock edge with push high and full low. The strength
// register (Q1.16, 65536 = 1.0, larger values act as 1.0) is to be written by
// the user with strength_we_i only while the block is idle; the block does not
// enforce this. Results leave through empty/pop, one per column in increasing
// order, last_o marking the end column. The front takes one pixel per cycle
// while full is low and runs the forward smoother. After a line is complete
// the back walks it backward, one column per cycle through the single read
// port of the line store, then offers the 64 results, one per cycle while pop
// is held. The first result of a line is ready once its backward walk is done;
// the back walks and emits one line before it takes the next. The store has
// two banks, so the next line loads while the previous one is walked and
// emitted; full rises only when both banks hold lines the back has not
// finished walking. A stalled receiver holds the current result and stops the
// emission; the front keeps loading until both banks are taken.
// Reset empties both sides and sets strength to one half.
module bidirectional_line_blur_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [blb_pkg::PIX_W-1:0]  pixel_i,
  input  logic                       strength_we_i,
  input  logic [blb_pkg::STR_W-1:0]  strength_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [blb_pkg::PIX_W-1:0]  pixel_out_o,
  output logic [blb_pkg::COL_W-1:0]  column_o,
  output logic                       last_o
);

  logic [blb_pkg::STR_W-1:0]  strength_q;
  logic [blb_pkg::STR_W-1:0]  strength_eff;
  blb_pkg::store_wr_t         store_wr;
  logic [blb_pkg::ADDR_W-1:0] rd_addr;
  logic [blb_pkg::WORD_W-1:0] rd_data;
  logic                       line_push;
  logic                       line_bank_in;
  logic                       line_pop;
  logic                       line_empty;
  logic                       line_bank_out;
  logic                       bank_release;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strength_q <= blb_pkg::StrengthRst;
    end else if (strength_we_i) begin
      strength_q <= strength_i;
    end
  end

  assign strength_eff = (strength_q > blb_pkg::StrengthOne) ? blb_pkg::StrengthOne
                                                            : strength_q;

  blb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .pixel_i     (pixel_i),
    .strength_i  (strength_eff),
    .release_i   (bank_release),
    .wr_o        (store_wr),
    .line_push_o (line_push),
    .line_bank_o (line_bank_in)
  );

  blb_line_store u_store (
    .clk_i     (clk_i),
    .wr_i      (store_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  blb_line_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (line_push),
    .bank_i  (line_bank_in),
    .pop_i   (line_pop),
    .empty_o (line_empty),
    .bank_o  (line_bank_out)
  );

  blb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .line_empty_i (line_empty),
    .line_bank_i  (line_bank_out),
    .line_pop_o   (line_pop),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .strength_i   (strength_eff),
    .release_o    (bank_release),
    .pop          (pop),
    .empty        (empty),
    .pixel_out_o  (pixel_out_o),
    .column_o     (column_o),
    .last_o       (last_o)
  );

endmodule

### sim/tb_top.sv
// self-checking testbench for the bidirectional line blur with a built-in line predictor
module tb_top;

  localparam int SETTLE_CYCLES = 80;
  localparam int TAIL_CYCLES   = 150;
  localparam int LONG_HOLD     = 1500;
  localparam int CYCLE_LIMIT   = 200000;

  typedef enum logic [1:0] {
    PLAN_PIXEL,
    PLAN_STRENGTH,
    PLAN_DRAIN,
    PLAN_HOLD
  } plan_kind_e;

  typedef struct {
    plan_kind_e  kind;
    int unsigned value;
  } plan_step_t;

  typedef struct packed {
    logic [blb_pkg::PIX_W-1:0] value;
    logic [blb_pkg::COL_W-1:0] col;
    logic                      last;
  } blur_result_t;

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      push          = 1'b0;
  logic                      full;
  logic [blb_pkg::PIX_W-1:0] pixel_i       = '0;
  logic                      strength_we_i = 1'b0;
  logic [blb_pkg::STR_W-1:0] strength_i    = '0;
  logic                      empty;
  logic                      pop           = 1'b0;
  logic [blb_pkg::PIX_W-1:0] pixel_out_o;
  logic [blb_pkg::COL_W-1:0] column_o;
  logic                      last_o;
  logic                      hold_kick     = 1'b0;

  plan_step_t   plan_q[$];
  blur_result_t blurred_q[$];

  // predictor state
  logic [blb_pkg::PIX_W-1:0]   src_line [blb_pkg::LINE_WIDTH];
  logic [blb_pkg::PIX_W-1:0]   fwd_line [blb_pkg::LINE_WIDTH];
  logic [blb_pkg::LEVEL_W-1:0] fwd_level     = '0;
  logic [blb_pkg::ADDR_W-1:0]  col_count     = '0;
  logic [blb_pkg::STR_W-1:0]   line_strength = blb_pkg::StrengthRst;

  int  err_count   = 0;
  int  gap_left    = 0;
  int  settle_left = 0;
  int  pop_wait    = 0;
  int  hold_left   = 0;
  int  cycle_count = 0;
  bit  send_steady = 1'b0;
  bit  recv_steady = 1'b0;

  bidirectional_line_blur_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .pixel_i      (pixel_i),
    .strength_we_i(strength_we_i),
    .strength_i   (strength_i),
    .empty        (empty),
    .pop          (pop),
    .pixel_out_o  (pixel_out_o),
    .column_o     (column_o),
    .last_o       (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int pause_len(input bit steady);
    return steady ? 0 : $urandom_range(0, 4);
  endfunction

  // forward smoother per pixel; backward walk and line emission on the end column
  function automatic void smooth_pixel(input logic [blb_pkg::PIX_W-1:0] pix);
    longint k, diff, lvl, d, b;
    int c, sum;
    logic [blb_pkg::BLEVEL_W-1:0] back;
    blur_result_t res;
    k = (line_strength > blb_pkg::StrengthOne) ? longint'(blb_pkg::StrengthOne)
                                                : longint'(line_strength);
    if (col_count == 0) fwd_level = {pix, 16'h0000};
    src_line[col_count[blb_pkg::COL_W-1:0]] = pix;
    diff = longint'({pix, 16'h0000}) - longint'(fwd_level);
    lvl = longint'(fwd_level) + ((diff * k) >>> blb_pkg::FRAC_W);
    fwd_level = lvl[blb_pkg::LEVEL_W-1:0];
    fwd_line[col_count[blb_pkg::COL_W-1:0]] =
      fwd_level[blb_pkg::LEVEL_W-1:blb_pkg::FRAC_W];
    col_count = col_count + 1'b1;
    if (col_count < blb_pkg::LINE_WIDTH) return;
    col_count = '0;
    back = {1'b0, fwd_line[blb_pkg::LastCol]};
    for (c = blb_pkg::LINE_WIDTH - 1; c > 0; c--) begin
      d = longint'(src_line[c]) - longint'(back);
      b = longint'(back) + (d * k) / 65536;
      if (b < 0) b = 0;
      if (b > longint'(blb_pkg::BLevelMax)) b = longint'(blb_pkg::BLevelMax);
      back = b[blb_pkg::BLEVEL_W-1:0];
      sum = int'(fwd_line[c]) + int'(back);
      fwd_line[c] = (sum > int'(blb_pkg::PixMax)) ? blb_pkg::PixMax
                                                   : sum[blb_pkg::PIX_W-1:0];
    end
    for (c = 0; c < blb_pkg::LINE_WIDTH; c++) begin
      res.value = fwd_line[c];
      res.col   = c[blb_pkg::COL_W-1:0];
      res.last  = (c == blb_pkg::LINE_WIDTH - 1);
      blurred_q.push_back(res);
    end
  endfunction

  function automatic void plan_add(input plan_kind_e kind, input int unsigned value);
    plan_step_t s;
    s.kind  = kind;
    s.value = value;
    plan_q.push_back(s);
  endfunction

  // one full line of random content in one of several shapes
  function automatic void plan_line();
    int style, base, stp, i, v;
    style = $urandom_range(0, 4);
    base  = $urandom_range(0, 255);
    stp   = $urandom_range(0, 16) - 8;
    for (i = 0; i < blb_pkg::LINE_WIDTH; i++) begin
      case (style)
        0: v = $urandom_range(0, 255);
        1: v = base;
        2: v = (base + i * stp) & 255;
        3: v = (i < blb_pkg::LINE_WIDTH / 2) ? base : 255 - base;
        default: v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : base;
      endcase
      plan_add(PLAN_PIXEL, v);
    end
  endfunction

  // sender: one request at a time from the plan
  always @(posedge clk_i) begin : sender
    logic                      nxt_push, nxt_we, nxt_kick;
    logic [blb_pkg::PIX_W-1:0] nxt_pix;
    logic [blb_pkg::STR_W-1:0] nxt_str;
    nxt_push = 1'b0;
    nxt_we   = 1'b0;
    nxt_kick = 1'b0;
    nxt_pix  = pixel_i;
    nxt_str  = strength_i;
    if (rst_ni) begin
      cycle_count++;
      if (strength_we_i) line_strength = strength_i;
      if (push && !full) smooth_pixel(pixel_i);
      if (push && full) begin
        nxt_push = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (settle_left > 0) begin
        settle_left--;
      end else if (plan_q.size() > 0) begin
        case (plan_q[0].kind)
          PLAN_PIXEL: begin
            nxt_push = 1'b1;
            nxt_pix  = plan_q[0].value[blb_pkg::PIX_W-1:0];
            void'(plan_q.pop_front());
            if ($urandom_range(0, 31) == 0) send_steady = !send_steady;
            gap_left = pause_len(send_steady);
          end
          PLAN_STRENGTH: begin
            nxt_we  = 1'b1;
            nxt_str = plan_q[0].value[blb_pkg::STR_W-1:0];
            void'(plan_q.pop_front());
          end
          PLAN_DRAIN: begin
            // results done, then give the back end time to go quiet
            if (blurred_q.size() == 0) begin
              settle_left = SETTLE_CYCLES;
              void'(plan_q.pop_front());
            end
          end
          default: begin
            nxt_kick = 1'b1;
            void'(plan_q.pop_front());
          end
        endcase
      end
    end
    push          <= nxt_push;
    pixel_i       <= nxt_pix;
    strength_we_i <= nxt_we;
    strength_i    <= nxt_str;
    hold_kick     <= nxt_kick;
  end

  // long receiver hold-off so the block fills up
  always @(posedge clk_i) begin
    if (hold_kick) hold_left <= LONG_HOLD;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // receiver and checker
  always @(posedge clk_i) begin : receiver
    blur_result_t want;
    logic         nxt_pop;
    nxt_pop = 1'b0;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (blurred_q.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected result: pixel %0d column %0d last %0d",
                     pixel_out_o, column_o, last_o);
        end else begin
          want = blurred_q.pop_front();
          if (pixel_out_o !== want.value || column_o !== want.col || last_o !== want.last) begin
            err_count++;
            if (err_count <= 10)
              $display("mismatch: expected pixel %0d column %0d last %0d, got %0d %0d %0d",
                       want.value, want.col, want.last, pixel_out_o, column_o, last_o);
          end
        end
        if ($urandom_range(0, 31) == 0) recv_steady = !recv_steady;
        pop_wait = pause_len(recv_steady);
      end else if (pop_wait > 0) begin
        pop_wait--;
      end
      nxt_pop = (pop_wait == 0) && (hold_left == 0);
    end
    pop <= nxt_pop;
  end

  always @(posedge clk_i) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int i;
    int directed [24];
    // directed opening: extremes, hard edges and small steps, then random fill
    directed = '{255, 0, 255, 0, 0, 0, 1, 254, 128, 127, 255, 255,
                 255, 0, 0, 0, 64, 192, 32, 224, 16, 240, 8, 247};
    // receiver holds off while four lines are offered, so both banks fill
    plan_add(PLAN_HOLD, 0);
    for (i = 0; i < 24; i++) plan_add(PLAN_PIXEL, directed[i]);
    for (i = 24; i < blb_pkg::LINE_WIDTH; i++) plan_add(PLAN_PIXEL, $urandom_range(0, 255));
    for (i = 0; i < 3; i++) plan_line();
    plan_add(PLAN_DRAIN, 0);
    plan_add(PLAN_STRENGTH, $urandom_range(1, 65535));
    plan_line();
    plan_add(PLAN_DRAIN, 0);
    // all strength bits set, acts as one
    plan_add(PLAN_STRENGTH, 17'h1FFFF);
    plan_line();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (plan_q.size() != 0 || push) @(posedge clk_i);
    while (blurred_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
